FILE: sv/zfp_pkg.sv
// ============================================================================
// zfp_pkg: shared types and constants of the API frame packer
// Payload structs, the job record passed from front to back, output step
// codes and the escape test.
// ============================================================================
package zfp_pkg;

    localparam logic [7:0] DELIM_BYTE = 8'h7E;
    localparam logic [7:0] ESC_BYTE   = 8'h7D;
    localparam logic [7:0] XON_BYTE   = 8'h11;
    localparam logic [7:0] XOFF_BYTE  = 8'h13;
    localparam logic [7:0] ESC_XOR    = 8'h20;
    localparam logic [7:0] CHK_INIT   = 8'hFF;

    localparam logic [1:0] MODE_ESCAPED = 2'd2;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_API_MODE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INSERT_ID = 2'd1;

    localparam int QUEUE_DEPTH_DEF = 2;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        first_byte;
        logic        last_byte;
        logic [15:0] data_length;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       frame_end;
        logic       run_last;
    } out_item_t;

    typedef struct packed {
        logic [1:0] api_mode;
        logic       insert_frame_id;
    } cfg_t;

    // One accepted item, fully classified: everything the back end needs.
    typedef struct packed {
        logic        first;
        logic        ins;
        logic        last;
        logic        esc;
        logic [7:0]  data;
        logic [7:0]  id;
        logic [15:0] len;
        logic [7:0]  chk;
    } job_t;

    typedef enum logic [5:0] {
        ST_DELIM = 6'b000001,
        ST_LENH  = 6'b000010,
        ST_LENL  = 6'b000100,
        ST_DATA  = 6'b001000,
        ST_ID    = 6'b010000,
        ST_CHK   = 6'b100000
    } step_t;

    function automatic logic is_special(input logic [7:0] b);
        is_special = b inside {DELIM_BYTE, ESC_BYTE, XON_BYTE, XOFF_BYTE};
    endfunction

endpackage

FILE: sv/zigbee_api_frame_packer.sv
// ============================================================================
// zigbee_api_frame_packer: API frame builder with optional byte stuffing
// Packs frame-data bytes into delimited, length-prefixed, checksummed frames.
// ============================================================================
// Usage:
// The s_ channel carries one frame-data byte per transfer, the first of a
// frame flagged by first_byte and carrying data_length, the last flagged by
// last_byte. The m_ channel carries one byte of the serialized frame per
// transfer; frame_end marks the last checksum byte and run_last the last
// byte produced for one input transfer.
// Each input transfer expands to 0 to 11 output bytes; a byte that arrives
// outside any frame is taken and dropped. The output sequencer emits one
// byte per cycle unless the receiver stalls it. An item has one or two
// output bytes for plain data (up to four with the checksum), four to
// eleven for the opening byte of a frame. With the queue empty, the first
// output byte passes through the job queue and then the output register.
// The classifier accepts a new transfer whenever the job queue has room, so
// it keeps taking input while the sequencer waits on a stalled receiver; when
// the queue fills, s_ready drops until the sequencer retires a job.
// Configuration is written through cfg_wr_en / cfg_index / cfg_wdata while
// the block is idle. Reset sets escaped mode, enables frame ID insertion,
// clears the frame ID counter, empties the queue and the output register.
// ============================================================================
module zigbee_api_frame_packer #(
    parameter int QUEUE_DEPTH = zfp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [zfp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [zfp_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  zfp_pkg::in_item_t               s_payload,
    output logic                            m_valid,
    input  logic                            m_ready,
    output zfp_pkg::out_item_t              m_payload
);

    // Configuration registers; writes to unused indexes are dropped.
    zfp_pkg::cfg_t cfg_reg, cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                zfp_pkg::REG_API_MODE:  cfg_next.api_mode        = cfg_wdata;
                zfp_pkg::REG_INSERT_ID: cfg_next.insert_frame_id = cfg_wdata[0];
                default:                cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.api_mode        <= zfp_pkg::MODE_ESCAPED;
            cfg_reg.insert_frame_id <= 1'b1;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Front end: classifies each transfer and computes checksum and frame ID.
    logic          q_full;
    logic          q_push;
    zfp_pkg::job_t q_job;

    zfp_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_job     (q_job)
    );

    // Job queue decoupling the two halves.
    logic          head_valid;
    zfp_pkg::job_t head_job;
    logic          q_pop;

    zfp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_job   (q_job),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    // Back end: serializes the head job, with byte stuffing in escaped mode.
    zfp_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head_job   (head_job),
        .pop        (q_pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_payload  (m_payload)
    );

    // A transfer that opens a frame always leaves a job in the queue.
    a_first_queued: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_payload.first_byte) |=> head_valid)
        else $error("opening transfer did not reach the job queue");

    // The checksum byte that closes a frame is always the end of its run.
    a_end_is_run_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_payload.frame_end) |-> m_payload.run_last)
        else $error("frame end without run end");

    // The sequencer never retires a job that is not there.
    a_pop_has_job: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> head_valid)
        else $error("job retired from an empty queue");

    // Nothing leaves the block in the cycle after reset.
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid right after reset");

endmodule

FILE: sv/zfp_front.sv
// ============================================================================
// zfp_front: item classifier of the API frame packer
// Tracks frame state, frame ID and checksum, and turns each accepted item
// inside a frame into a job record for the output sequencer.
// ============================================================================
module zfp_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  zfp_pkg::cfg_t     cfg,
    input  logic              s_valid,
    output logic              s_ready,
    input  zfp_pkg::in_item_t s_payload,
    input  logic              q_full,
    output logic              q_push,
    output zfp_pkg::job_t     q_job
);

    logic [7:0] frame_id_reg, frame_id_next;
    logic [7:0] chk_reg, chk_next;
    logic       in_frame_reg, in_frame_next;

    logic       accept;
    logic       ins;
    logic [7:0] id_use;
    logic [7:0] base;
    logic [7:0] after_data;
    logic [7:0] after_id;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;
    assign q_push  = accept && (s_payload.first_byte || in_frame_reg);

    assign ins        = s_payload.first_byte && cfg.insert_frame_id;
    assign id_use     = (frame_id_reg == 8'd0) ? 8'd1 : frame_id_reg;
    assign base       = s_payload.first_byte ? zfp_pkg::CHK_INIT : chk_reg;
    assign after_data = base - s_payload.data_byte;
    assign after_id   = ins ? (after_data - id_use) : after_data;

    always_comb begin
        q_job.first = s_payload.first_byte;
        q_job.ins   = ins;
        q_job.last  = s_payload.last_byte;
        q_job.esc   = (cfg.api_mode == zfp_pkg::MODE_ESCAPED);
        q_job.data  = s_payload.data_byte;
        q_job.id    = id_use;
        q_job.len   = s_payload.data_length + {15'd0, ins};
        q_job.chk   = after_id;
    end

    always_comb begin
        frame_id_next = frame_id_reg;
        chk_next      = chk_reg;
        in_frame_next = in_frame_reg;
        if (q_push) begin
            if (ins) begin
                frame_id_next = id_use + 8'd1;
            end
            chk_next      = s_payload.last_byte ? zfp_pkg::CHK_INIT : after_id;
            in_frame_next = !s_payload.last_byte;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_id_reg <= 8'd0;
            chk_reg      <= zfp_pkg::CHK_INIT;
            in_frame_reg <= 1'b0;
        end else begin
            frame_id_reg <= frame_id_next;
            chk_reg      <= chk_next;
            in_frame_reg <= in_frame_next;
        end
    end

endmodule

FILE: sv/zfp_queue.sv
// ============================================================================
// zfp_queue: job queue between classifier and output sequencer
// A small register FIFO that lets either side stall on its own.
// ============================================================================
module zfp_queue #(
    parameter int DEPTH = zfp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  zfp_pkg::job_t push_job,
    output logic          full,
    input  logic          pop,
    output logic          head_valid,
    output zfp_pkg::job_t head_job
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    zfp_pkg::job_t entry_reg [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_job   = entry_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

FILE: sv/zfp_back.sv
// ============================================================================
// zfp_back: output sequencer of the API frame packer
// Walks the bytes of the job at the queue head, stuffing them in escaped
// mode; drives the registered result channel, one byte per unstalled cycle.
// ============================================================================
module zfp_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               head_valid,
    input  zfp_pkg::job_t      head_job,
    output logic               pop,
    output logic               m_valid,
    input  logic               m_ready,
    output zfp_pkg::out_item_t m_payload
);

    zfp_pkg::step_t     step_reg, step_next;
    logic               busy_reg, busy_next;
    logic               half_reg, half_next;
    logic               m_valid_reg, m_valid_next;
    zfp_pkg::out_item_t m_payload_reg;

    zfp_pkg::step_t cur_step;
    zfp_pkg::step_t nxt_step;
    logic           job_done;
    logic [7:0]     cur_byte;
    logic           need_esc;
    logic           step_done;
    logic           fire;
    logic [7:0]     emit_byte;

    assign cur_step = busy_reg ? step_reg :
                      (head_job.first ? zfp_pkg::ST_DELIM : zfp_pkg::ST_DATA);

    always_comb begin
        case (cur_step)
            zfp_pkg::ST_DELIM: cur_byte = zfp_pkg::DELIM_BYTE;
            zfp_pkg::ST_LENH:  cur_byte = head_job.len[15:8];
            zfp_pkg::ST_LENL:  cur_byte = head_job.len[7:0];
            zfp_pkg::ST_ID:    cur_byte = head_job.id;
            zfp_pkg::ST_CHK:   cur_byte = head_job.chk;
            default:           cur_byte = head_job.data;
        endcase
    end

    always_comb begin
        nxt_step = zfp_pkg::ST_DATA;
        job_done = 1'b0;
        case (cur_step)
            zfp_pkg::ST_DELIM: nxt_step = zfp_pkg::ST_LENH;
            zfp_pkg::ST_LENH:  nxt_step = zfp_pkg::ST_LENL;
            zfp_pkg::ST_LENL:  nxt_step = zfp_pkg::ST_DATA;
            zfp_pkg::ST_DATA: begin
                if (head_job.ins) begin
                    nxt_step = zfp_pkg::ST_ID;
                end else if (head_job.last) begin
                    nxt_step = zfp_pkg::ST_CHK;
                end else begin
                    job_done = 1'b1;
                end
            end
            zfp_pkg::ST_ID: begin
                if (head_job.last) begin
                    nxt_step = zfp_pkg::ST_CHK;
                end else begin
                    job_done = 1'b1;
                end
            end
            default: job_done = 1'b1;
        endcase
    end

    // The delimiter is never stuffed; every later byte may be.
    assign need_esc  = head_job.esc && (cur_step != zfp_pkg::ST_DELIM) &&
                       zfp_pkg::is_special(cur_byte);
    assign step_done = !need_esc || half_reg;
    assign emit_byte = half_reg ? (cur_byte ^ zfp_pkg::ESC_XOR) :
                       (need_esc ? zfp_pkg::ESC_BYTE : cur_byte);
    assign fire      = head_valid && (!m_valid_reg || m_ready);
    assign pop       = fire && step_done && job_done;

    always_comb begin
        step_next    = step_reg;
        busy_next    = busy_reg;
        half_next    = half_reg;
        m_valid_next = m_valid_reg && !m_ready;
        if (fire) begin
            m_valid_next = 1'b1;
            if (!step_done) begin
                half_next = 1'b1;
                busy_next = 1'b1;
                step_next = cur_step;
            end else begin
                half_next = 1'b0;
                busy_next = !job_done;
                step_next = nxt_step;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg    <= zfp_pkg::ST_DATA;
            busy_reg    <= 1'b0;
            half_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            step_reg    <= step_next;
            busy_reg    <= busy_next;
            half_reg    <= half_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            m_payload_reg.out_byte  <= emit_byte;
            m_payload_reg.frame_end <= step_done && job_done &&
                                       (cur_step == zfp_pkg::ST_CHK);
            m_payload_reg.run_last  <= step_done && job_done;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

endmodule
